[rtl/core/dbpc_pkg.sv]
// Shared types and constants for the dE/dx band particle classifier.
`default_nettype none
package dbpc_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_ETA_LIMIT       = 3'd0;
	localparam logic [2:0] REG_PION_P_MIN      = 3'd1;
	localparam logic [2:0] REG_PION_P_MAX      = 3'd2;
	localparam logic [2:0] REG_PION_DEDX_MIN   = 3'd3;
	localparam logic [2:0] REG_KAON_P_MAX      = 3'd4;
	localparam logic [2:0] REG_KAON_DEDX_MIN   = 3'd5;
	localparam logic [2:0] REG_PROTON_P_MAX    = 3'd6;
	localparam logic [2:0] REG_PROTON_DEDX_MIN = 3'd7;

	// Register reset values.
	localparam logic [14:0] RST_ETA_LIMIT       = 15'd3277;
	localparam logic [15:0] RST_PION_P_MIN      = 16'd614;
	localparam logic [15:0] RST_PION_P_MAX      = 16'd4096;
	localparam logic [15:0] RST_PION_DEDX_MIN   = 16'd51;
	localparam logic [15:0] RST_KAON_P_MAX      = 16'd3686;
	localparam logic [15:0] RST_KAON_DEDX_MIN   = 16'd819;
	localparam logic [15:0] RST_PROTON_P_MAX    = 16'd6554;
	localparam logic [15:0] RST_PROTON_DEDX_MIN = 16'd870;

	// Class codes.
	localparam logic [1:0] CLASS_NONE   = 2'd0;
	localparam logic [1:0] CLASS_PION   = 2'd1;
	localparam logic [1:0] CLASS_KAON   = 2'd2;
	localparam logic [1:0] CLASS_PROTON = 2'd3;

	// Curve offsets in momentum units (1/4096 GeV/c).
	localparam logic [15:0] C_OFF0 = 16'd0;
	localparam logic [15:0] C_OFF1 = 16'd205;
	localparam logic [15:0] C_OFF2 = 16'd614;

	// Curve bases in energy loss units (1/256).
	localparam logic [15:0] B_BASE0 = 16'd563;
	localparam logic [15:0] B_BASE1 = 16'd640;
	localparam logic [15:0] B_BASE2 = 16'd768;

	// Curve numerators in units of 2^-32.
	localparam logic signed [49:0] A_PION_HI = 50'sd1245540516;
	localparam logic signed [49:0] A_KAON_LO = 50'sd1288490189;
	localparam logic signed [49:0] A_KAON_HI = 50'sd3006477107;
	localparam logic signed [49:0] A_PROT_LO = 50'sd3865470566;
	localparam logic signed [49:0] A_PROT_HI = 50'sd10307921510;

	typedef struct packed {
		logic [14:0] eta_limit;
		logic [15:0] pion_p_min;
		logic [15:0] pion_p_max;
		logic [15:0] pion_dedx_min;
		logic [15:0] kaon_p_max;
		logic [15:0] kaon_dedx_min;
		logic [15:0] proton_p_max;
		logic [15:0] proton_dedx_min;
	} cfg_t;

	typedef struct packed {
		logic eta_ok;
		logic pion_cut;
		logic kaon_cut;
		logic proton_cut;
	} cut_t;

	// Stage 1: distances to the curve offsets and energy loss minus bases.
	typedef struct packed {
		cut_t        cut;
		logic [2:0]  pole;
		logic [15:0] dist0;
		logic [15:0] dist1;
		logic [15:0] dist2;
		logic [16:0] eb0;
		logic [16:0] eb1;
		logic [16:0] eb2;
	} prep_t;

	// Stage 2: squared distances.
	typedef struct packed {
		cut_t        cut;
		logic [2:0]  pole;
		logic [31:0] sq0;
		logic [31:0] sq1;
		logic [31:0] sq2;
		logic [16:0] eb0;
		logic [16:0] eb1;
		logic [16:0] eb2;
	} sq_t;

	// Stage 3: scaled products (dEdx - b) * (p - c)^2.
	typedef struct packed {
		cut_t               cut;
		logic [2:0]         pole;
		logic signed [49:0] prod0;
		logic signed [49:0] prod1;
		logic signed [49:0] prod2;
	} prod_t;

endpackage
`default_nettype wire

[rtl/core/dbpc_prep.sv]
// First pipeline stage: cuts, distances to curve offsets and energy loss offsets.
`default_nettype none
module dbpc_prep (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [15:0]     momentum,
	input  wire logic [15:0]     energy_loss,
	input  wire logic [15:0]     pseudorapidity,
	input  wire dbpc_pkg::cfg_t  cfg,
	output logic                 valid_s1,
	output dbpc_pkg::prep_t      prep_s1
);

	logic [16:0]     abs_eta;
	dbpc_pkg::prep_t prep_d;

	always_comb begin
		// Sign-extend to 17 bits so that -32768 gives a magnitude of 32768.
		if (pseudorapidity[15]) begin
			abs_eta = 17'd0 - {1'b1, pseudorapidity};
		end else begin
			abs_eta = {1'b0, pseudorapidity};
		end

		prep_d.cut.eta_ok     = abs_eta <= {2'b00, cfg.eta_limit};
		prep_d.cut.pion_cut   = (momentum < cfg.pion_p_max) && (cfg.pion_p_min < momentum)
			&& (cfg.pion_dedx_min < energy_loss);
		prep_d.cut.kaon_cut   = (momentum < cfg.kaon_p_max) && (cfg.kaon_dedx_min < energy_loss);
		prep_d.cut.proton_cut = (momentum < cfg.proton_p_max)
			&& (cfg.proton_dedx_min < energy_loss);

		prep_d.pole[0] = momentum == dbpc_pkg::C_OFF0;
		prep_d.pole[1] = momentum == dbpc_pkg::C_OFF1;
		prep_d.pole[2] = momentum == dbpc_pkg::C_OFF2;

		prep_d.dist0 = momentum - dbpc_pkg::C_OFF0;
		prep_d.dist1 = (momentum >= dbpc_pkg::C_OFF1) ? momentum - dbpc_pkg::C_OFF1
			: dbpc_pkg::C_OFF1 - momentum;
		prep_d.dist2 = (momentum >= dbpc_pkg::C_OFF2) ? momentum - dbpc_pkg::C_OFF2
			: dbpc_pkg::C_OFF2 - momentum;

		prep_d.eb0 = {1'b0, energy_loss} - {1'b0, dbpc_pkg::B_BASE0};
		prep_d.eb1 = {1'b0, energy_loss} - {1'b0, dbpc_pkg::B_BASE1};
		prep_d.eb2 = {1'b0, energy_loss} - {1'b0, dbpc_pkg::B_BASE2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			prep_s1 <= prep_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/dbpc_band.sv]
// Second and third pipeline stages: squares of the distances, then the band products.
`default_nettype none
module dbpc_band (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	input  wire dbpc_pkg::prep_t  prep_s1,
	output logic                  valid_s3,
	output dbpc_pkg::prod_t       prod_s3
);

	logic          valid_s2;
	dbpc_pkg::sq_t sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sq_s2.cut  <= prep_s1.cut;
			sq_s2.pole <= prep_s1.pole;
			sq_s2.sq0  <= 32'(prep_s1.dist0) * 32'(prep_s1.dist0);
			sq_s2.sq1  <= 32'(prep_s1.dist1) * 32'(prep_s1.dist1);
			sq_s2.sq2  <= 32'(prep_s1.dist2) * 32'(prep_s1.dist2);
			sq_s2.eb0  <= prep_s1.eb0;
			sq_s2.eb1  <= prep_s1.eb1;
			sq_s2.eb2  <= prep_s1.eb2;
		end
	end

	// The energy loss offset is signed; the square is a non-negative 32-bit value.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			prod_s3.cut   <= sq_s2.cut;
			prod_s3.pole  <= sq_s2.pole;
			prod_s3.prod0 <= $signed(sq_s2.eb0) * $signed({18'd0, sq_s2.sq0});
			prod_s3.prod1 <= $signed(sq_s2.eb1) * $signed({18'd0, sq_s2.sq1});
			prod_s3.prod2 <= $signed(sq_s2.eb2) * $signed({18'd0, sq_s2.sq2});
		end
	end

endmodule
`default_nettype wire

[rtl/core/dbpc_select.sv]
// Last pipeline stage: curve comparisons, priority selection and result register.
`default_nettype none
module dbpc_select (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s3,
	input  wire dbpc_pkg::prod_t  prod_s3,
	output logic                  done,
	output logic [1:0]            particle_class
);

	logic       is_pion;
	logic       is_kaon;
	logic       is_proton;
	logic [1:0] class_d;

	always_comb begin
		// A pole makes the curve infinite: below holds, above fails.
		is_pion = prod_s3.cut.pion_cut
			&& (prod_s3.pole[0] || (prod_s3.prod0 < dbpc_pkg::A_PION_HI));
		is_kaon = prod_s3.cut.kaon_cut
			&& !prod_s3.pole[0] && (dbpc_pkg::A_KAON_LO < prod_s3.prod0)
			&& (prod_s3.pole[1] || (prod_s3.prod1 < dbpc_pkg::A_KAON_HI));
		is_proton = prod_s3.cut.proton_cut
			&& !prod_s3.pole[1] && (dbpc_pkg::A_PROT_LO < prod_s3.prod1)
			&& (prod_s3.pole[2] || (prod_s3.prod2 < dbpc_pkg::A_PROT_HI));

		if (!prod_s3.cut.eta_ok) begin
			class_d = dbpc_pkg::CLASS_NONE;
		end else if (is_pion) begin
			class_d = dbpc_pkg::CLASS_PION;
		end else if (is_kaon) begin
			class_d = dbpc_pkg::CLASS_KAON;
		end else if (is_proton) begin
			class_d = dbpc_pkg::CLASS_PROTON;
		end else begin
			class_d = dbpc_pkg::CLASS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			particle_class <= class_d;
		end
	end

endmodule
`default_nettype wire

[rtl/core/dedx_band_particle_classifier_core.sv]
// Top level of the dE/dx band particle classifier: registers, pipeline and checks.
//
// Channel   Direction  Handshake            Payload
// track     in         start (busy low)     momentum, energy_loss, pseudorapidity
// result    out        done (one cycle)     particle_class
// config    in         cfg_we               cfg_index, cfg_wdata
//
// The block takes one track every clock cycle; busy is never raised.
// Each result appears on done once its track has passed these stages: one
// stage for cuts and offsets, one for the squared distance, one for the
// 17 x 32 bit band product, and one for the compares and the output register.
// Reset clears the valid bits and loads the register defaults; the receiver
// cannot stall, so results leave in order at the rate tracks arrive.
`default_nettype none
module dedx_band_particle_classifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [15:0] momentum,
	input  wire logic [15:0] energy_loss,
	input  wire logic [15:0] pseudorapidity,
	output logic             done,
	output logic [1:0]       particle_class,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	dbpc_pkg::cfg_t  cfg_q;
	dbpc_pkg::prep_t prep_s1;
	dbpc_pkg::prod_t prod_s3;
	logic            valid_s1;
	logic            valid_s3;
	logic            accept;

	// The pipeline never holds off a track.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration registers. The user must make writes only while no track is in flight,
	// so the first stage may read them directly; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eta_limit       <= dbpc_pkg::RST_ETA_LIMIT;
			cfg_q.pion_p_min      <= dbpc_pkg::RST_PION_P_MIN;
			cfg_q.pion_p_max      <= dbpc_pkg::RST_PION_P_MAX;
			cfg_q.pion_dedx_min   <= dbpc_pkg::RST_PION_DEDX_MIN;
			cfg_q.kaon_p_max      <= dbpc_pkg::RST_KAON_P_MAX;
			cfg_q.kaon_dedx_min   <= dbpc_pkg::RST_KAON_DEDX_MIN;
			cfg_q.proton_p_max    <= dbpc_pkg::RST_PROTON_P_MAX;
			cfg_q.proton_dedx_min <= dbpc_pkg::RST_PROTON_DEDX_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				dbpc_pkg::REG_ETA_LIMIT:       cfg_q.eta_limit       <= cfg_wdata[14:0];
				dbpc_pkg::REG_PION_P_MIN:      cfg_q.pion_p_min      <= cfg_wdata;
				dbpc_pkg::REG_PION_P_MAX:      cfg_q.pion_p_max      <= cfg_wdata;
				dbpc_pkg::REG_PION_DEDX_MIN:   cfg_q.pion_dedx_min   <= cfg_wdata;
				dbpc_pkg::REG_KAON_P_MAX:      cfg_q.kaon_p_max      <= cfg_wdata;
				dbpc_pkg::REG_KAON_DEDX_MIN:   cfg_q.kaon_dedx_min   <= cfg_wdata;
				dbpc_pkg::REG_PROTON_P_MAX:    cfg_q.proton_p_max    <= cfg_wdata;
				dbpc_pkg::REG_PROTON_DEDX_MIN: cfg_q.proton_dedx_min <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Stage 1: the eta window, momentum and energy loss cuts, and the signed
	// offsets that feed the band curves.
	dbpc_prep u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (accept),
		.momentum       (momentum),
		.energy_loss    (energy_loss),
		.pseudorapidity (pseudorapidity),
		.cfg            (cfg_q),
		.valid_s1       (valid_s1),
		.prep_s1        (prep_s1)
	);

	// Stages 2 and 3: the curves are compared by cross-multiplication, so
	// the distance is squared and then scaled by the energy loss offset.
	// The pion and kaon curves share one offset pair, as do the kaon and
	// proton curves, so three products cover all five curves.
	dbpc_band u_band (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.prep_s1  (prep_s1),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3)
	);

	// Stage 4: compares against the curve numerators, first match wins.
	dbpc_select u_select (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s3       (valid_s3),
		.prod_s3        (prod_s3),
		.done           (done),
		.particle_class (particle_class)
	);

	// Every accepted track gives exactly one result.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted track produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result without an accepted track");

	// A track outside the eta window always leaves unclassified.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !prep_s1.cut.eta_ok) |-> ##3
		(done && (particle_class == dbpc_pkg::CLASS_NONE)))
		else $error("track outside eta window was classified");

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the dE/dx band particle classifier core.
module tb_top;

	// Band curve coefficients in the block's fixed-point formats. Numerators are
	// in units of 2^-32, bases in 1/256 energy loss units, offsets in 1/4096 GeV/c.
	localparam longint NUM_PION_HI = 64'd1245540516;
	localparam longint NUM_KAON_LO = 64'd1288490189;
	localparam longint NUM_KAON_HI = 64'd3006477107;
	localparam longint NUM_PROT_LO = 64'd3865470566;
	localparam longint NUM_PROT_HI = 64'd10307921510;
	localparam longint BASE_2P2    = 563;
	localparam longint BASE_2P5    = 640;
	localparam longint BASE_3P0    = 768;
	localparam longint OFS_0P00    = 0;
	localparam longint OFS_0P05    = 205;
	localparam longint OFS_0P15    = 614;

	// Cycles to wait after every predicted class has come back.
	localparam int SETTLE_CYCLES = 12;
	// Worst case is roughly 1100 items, each followed by the largest gap, plus drains; far above it.
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 10;

	typedef enum logic [1:0] {
		ACT_TRACK,
		ACT_CFG_WRITE,
		ACT_DRAIN
	} plan_act_t;

	// One step of the stimulus plan: a track, a register write, or a pause that
	// holds the sender until every predicted class has come back.
	typedef struct {
		plan_act_t   act;
		logic [15:0] momentum;
		logic [15:0] energy_loss;
		logic [15:0] pseudorapidity;
		logic [2:0]  index;
		logic [15:0] data;
		int          gap;
	} plan_item_t;

	// A predicted class together with the track it belongs to, for reporting.
	typedef struct {
		logic [1:0]  cls;
		int          serial;
		logic [15:0] momentum;
		logic [15:0] energy_loss;
		logic [15:0] pseudorapidity;
	} predicted_class_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [15:0] momentum;
	logic [15:0] energy_loss;
	logic [15:0] pseudorapidity;
	logic        done;
	logic [1:0]  particle_class;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	plan_item_t       track_plan_q[$];
	predicted_class_t predicted_class_q[$];

	// Register copy used by the predictor; it follows the writes seen at the port.
	dbpc_pkg::cfg_t cuts;
	// Register values as planned, so random tracks can aim at the current cuts.
	logic [15:0] next_cuts [8];
	int          plan_eta_lim;

	logic        track_taken;
	logic        drv_start;
	logic        drv_we;
	plan_item_t  plan_step;
	int          gap_left;
	int          calm_left;

	int          cycle_count;
	int          fail_count;
	int          track_count;
	int          result_count;
	int          write_count;
	int          setting_count;
	int          drain_count;
	int          class_seen [4];

	dedx_band_particle_classifier_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.momentum       (momentum),
		.energy_loss    (energy_loss),
		.pseudorapidity (pseudorapidity),
		.done           (done),
		.particle_class (particle_class),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Band tests. A curve is f(p) = a/(p-c)^2 + b, compared by multiplying
	// out the square so no division is needed. At the pole p == c the curve
	// is infinite: the track is always below it and never above it.
	// ------------------------------------------------------------------
	function automatic bit under_band(input longint p, input longint e, input longint a,
			input longint b, input longint c);
		longint d2;
		d2 = (p - c) * (p - c);
		if (d2 == 0) begin
			return 1'b1;
		end
		return (e - b) * d2 < a;
	endfunction

	function automatic bit over_band(input longint p, input longint e, input longint a,
			input longint b, input longint c);
		longint d2;
		d2 = (p - c) * (p - c);
		if (d2 == 0) begin
			return 1'b0;
		end
		return a < (e - b) * d2;
	endfunction

	// Predicts the class of one track from the current register copy. The eta
	// cut comes first, then pion, kaon and proton in that order; first match wins.
	// The eta limit itself passes, other cuts are strict; -32768 has a magnitude beyond any limit.
	function automatic logic [1:0] classify_track(input logic [15:0] p_raw,
			input logic [15:0] e_raw, input logic signed [15:0] eta_raw);
		longint p;
		longint e;
		longint eta_mag;
		p = p_raw;
		e = e_raw;
		eta_mag = eta_raw;
		if (eta_mag < 0) begin
			eta_mag = -eta_mag;
		end
		if (eta_mag > longint'(cuts.eta_limit)) begin
			return dbpc_pkg::CLASS_NONE;
		end
		if (under_band(p, e, NUM_PION_HI, BASE_2P2, OFS_0P00)
				&& p < longint'(cuts.pion_p_max) && longint'(cuts.pion_p_min) < p
				&& longint'(cuts.pion_dedx_min) < e) begin
			return dbpc_pkg::CLASS_PION;
		end
		if (over_band(p, e, NUM_KAON_LO, BASE_2P2, OFS_0P00)
				&& under_band(p, e, NUM_KAON_HI, BASE_2P5, OFS_0P05)
				&& p < longint'(cuts.kaon_p_max) && longint'(cuts.kaon_dedx_min) < e) begin
			return dbpc_pkg::CLASS_KAON;
		end
		if (over_band(p, e, NUM_PROT_LO, BASE_2P5, OFS_0P05)
				&& under_band(p, e, NUM_PROT_HI, BASE_3P0, OFS_0P15)
				&& p < longint'(cuts.proton_p_max)
				&& longint'(cuts.proton_dedx_min) < e) begin
			return dbpc_pkg::CLASS_PROTON;
		end
		return dbpc_pkg::CLASS_NONE;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning.
	// ------------------------------------------------------------------
	function automatic longint rnd(input longint lo, input longint hi);
		return lo + longint'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic longint clamp16(input longint v);
		if (v < 0) begin
			return 0;
		end
		if (v > 65535) begin
			return 65535;
		end
		return v;
	endfunction

	// More than half the tracks go back to back; the rest are followed by a random gap. Now and then
	// a run of tracks with no gap at all is inserted.
	function automatic int draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		if ($urandom_range(0, 1) == 0) begin
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	task automatic plan_track(input longint p, input longint e, input longint eta);
		plan_item_t it;
		it.act = ACT_TRACK;
		it.momentum = 16'(clamp16(p));
		it.energy_loss = 16'(clamp16(e));
		it.pseudorapidity = 16'(eta);
		it.index = '0;
		it.data = '0;
		it.gap = draw_gap();
		track_plan_q.push_back(it);
	endtask

	task automatic plan_drain();
		plan_item_t it;
		it = '{act: ACT_DRAIN, momentum: '0, energy_loss: '0, pseudorapidity: '0,
			index: '0, data: '0, gap: 0};
		track_plan_q.push_back(it);
	endtask

	// Writes every register from next_cuts, after the pipeline has emptied.
	task automatic plan_cuts();
		plan_item_t it;
		int         i;
		plan_drain();
		for (i = 0; i < 8; i++) begin
			it = '{act: ACT_CFG_WRITE, momentum: '0, energy_loss: '0, pseudorapidity: '0,
				index: 3'(i), data: next_cuts[i], gap: 0};
			track_plan_q.push_back(it);
		end
		plan_eta_lim = int'(next_cuts[dbpc_pkg::REG_ETA_LIMIT] & 16'h7FFF);
		setting_count++;
	endtask

	task automatic load_default_cuts();
		next_cuts[dbpc_pkg::REG_ETA_LIMIT]       = 16'(dbpc_pkg::RST_ETA_LIMIT);
		next_cuts[dbpc_pkg::REG_PION_P_MIN]      = dbpc_pkg::RST_PION_P_MIN;
		next_cuts[dbpc_pkg::REG_PION_P_MAX]      = dbpc_pkg::RST_PION_P_MAX;
		next_cuts[dbpc_pkg::REG_PION_DEDX_MIN]   = dbpc_pkg::RST_PION_DEDX_MIN;
		next_cuts[dbpc_pkg::REG_KAON_P_MAX]      = dbpc_pkg::RST_KAON_P_MAX;
		next_cuts[dbpc_pkg::REG_KAON_DEDX_MIN]   = dbpc_pkg::RST_KAON_DEDX_MIN;
		next_cuts[dbpc_pkg::REG_PROTON_P_MAX]    = dbpc_pkg::RST_PROTON_P_MAX;
		next_cuts[dbpc_pkg::REG_PROTON_DEDX_MIN] = dbpc_pkg::RST_PROTON_DEDX_MIN;
	endtask

	// Each register either lands near its default (up to twice it) or anywhere
	// in the full 16-bit range. Bit 15 of eta_limit is exercised by the latter.
	task automatic draw_random_cuts();
		int i;
		load_default_cuts();
		for (i = 0; i < 8; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				next_cuts[i] = 16'(rnd(0, 2 * longint'(next_cuts[i])));
			end else begin
				next_cuts[i] = 16'(rnd(0, 65535));
			end
		end
	endtask

	// Random tracks. Most sit right at a band curve, at a momentum cut or at an
	// energy loss cut of the current setting, where the decisions flip; the rest
	// are fully random in every bit. Eta mostly spans the current window and one step past each side.
	task automatic plan_random_tracks(input int count);
		int     n;
		int     kind;
		longint p;
		longint e;
		longint eta;
		longint a;
		longint b;
		longint c;
		for (n = 0; n < count; n++) begin
			kind = $urandom_range(0, 9);
			eta = rnd(0, 2 * plan_eta_lim + 2) - plan_eta_lim - 1;
			if (kind < 5) begin
				case ($urandom_range(0, 4))
					0: begin
						a = NUM_PION_HI; b = BASE_2P2; c = OFS_0P00;
					end
					1: begin
						a = NUM_KAON_LO; b = BASE_2P2; c = OFS_0P00;
					end
					2: begin
						a = NUM_KAON_HI; b = BASE_2P5; c = OFS_0P05;
					end
					3: begin
						a = NUM_PROT_LO; b = BASE_2P5; c = OFS_0P05;
					end
					default: begin
						a = NUM_PROT_HI; b = BASE_3P0; c = OFS_0P15;
					end
				endcase
				p = ($urandom_range(0, 19) == 0) ? c : rnd(0, 8191);
				if (p == c) begin
					e = rnd(0, 65535);
				end else begin
					e = b + a / ((p - c) * (p - c)) + rnd(-3, 3);
				end
			end else if (kind < 7) begin
				case ($urandom_range(0, 3))
					0: p = next_cuts[dbpc_pkg::REG_PION_P_MIN];
					1: p = next_cuts[dbpc_pkg::REG_PION_P_MAX];
					2: p = next_cuts[dbpc_pkg::REG_KAON_P_MAX];
					default: p = next_cuts[dbpc_pkg::REG_PROTON_P_MAX];
				endcase
				p = p + rnd(-2, 2);
				e = rnd(0, 3000);
			end else if (kind == 7) begin
				p = rnd(0, 8191);
				case ($urandom_range(0, 2))
					0: e = next_cuts[dbpc_pkg::REG_PION_DEDX_MIN];
					1: e = next_cuts[dbpc_pkg::REG_KAON_DEDX_MIN];
					default: e = next_cuts[dbpc_pkg::REG_PROTON_DEDX_MIN];
				endcase
				e = e + rnd(-2, 2);
			end else begin
				p = rnd(0, 65535);
				e = rnd(0, 65535);
				eta = rnd(0, 65535);
			end
			plan_track(p, e, eta);
			// Occasionally hold the sender until the pipeline has run dry.
			if ($urandom_range(0, 79) == 0) begin
				plan_drain();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: changes inputs on the falling edge. A track stays on the port
	// until an edge with busy low takes it; then the planned gap follows.
	// Register writes last one cycle. A drain step waits for an empty pipeline.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			drv_start = start && !track_taken;
			drv_we = 1'b0;
			if (!drv_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (track_plan_q.size() > 0) begin
					plan_step = track_plan_q[0];
					case (plan_step.act)
						ACT_TRACK: begin
							momentum <= plan_step.momentum;
							energy_loss <= plan_step.energy_loss;
							pseudorapidity <= plan_step.pseudorapidity;
							drv_start = 1'b1;
							gap_left = plan_step.gap;
							void'(track_plan_q.pop_front());
						end
						ACT_CFG_WRITE: begin
							cfg_index <= plan_step.index;
							cfg_wdata <= plan_step.data;
							drv_we = 1'b1;
							void'(track_plan_q.pop_front());
						end
						default: begin
							if (predicted_class_q.size() == 0) begin
								drain_count++;
								void'(track_plan_q.pop_front());
							end
						end
					endcase
				end
			end
			start <= drv_start;
			cfg_we <= drv_we;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: everything is sampled on the rising edge. A result is compared
	// with the oldest prediction; an accepted track gets its class predicted
	// from the register copy; a register write updates that copy.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		predicted_class_t exp_item;
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d classes still pending", cycle_count,
				predicted_class_q.size());
			$display("Test completed with failures");
			$finish;
		end
		track_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (predicted_class_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("Unexpected result: class %0d with no track pending",
							particle_class);
					end
				end else begin
					exp_item = predicted_class_q.pop_front();
					if (particle_class !== exp_item.cls) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("Mismatch on track %0d (p=%0d dedx=%0d eta=%0d): %s %0d, %s %0d",
								exp_item.serial, exp_item.momentum, exp_item.energy_loss,
								$signed(exp_item.pseudorapidity), "expected class", exp_item.cls,
								"got", particle_class);
						end
					end
				end
			end
			if (start && !busy) begin
				exp_item.cls = classify_track(momentum, energy_loss, pseudorapidity);
				exp_item.serial = track_count;
				exp_item.momentum = momentum;
				exp_item.energy_loss = energy_loss;
				exp_item.pseudorapidity = pseudorapidity;
				predicted_class_q.push_back(exp_item);
				class_seen[exp_item.cls]++;
				track_count++;
				track_taken = 1'b1;
			end
			if (cfg_we) begin
				write_count++;
				case (cfg_index)
					dbpc_pkg::REG_ETA_LIMIT:     cuts.eta_limit = cfg_wdata[14:0];
					dbpc_pkg::REG_PION_P_MIN:    cuts.pion_p_min = cfg_wdata;
					dbpc_pkg::REG_PION_P_MAX:    cuts.pion_p_max = cfg_wdata;
					dbpc_pkg::REG_PION_DEDX_MIN: cuts.pion_dedx_min = cfg_wdata;
					dbpc_pkg::REG_KAON_P_MAX:    cuts.kaon_p_max = cfg_wdata;
					dbpc_pkg::REG_KAON_DEDX_MIN: cuts.kaon_dedx_min = cfg_wdata;
					dbpc_pkg::REG_PROTON_P_MAX:  cuts.proton_p_max = cfg_wdata;
					default:                     cuts.proton_dedx_min = cfg_wdata;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence: build the whole plan, reset once, then let the driver run
	// it and wait for the pipeline to empty.
	// ------------------------------------------------------------------
	initial begin
		int i;
		arst_n = 1'b0;
		start = 1'b0;
		momentum = '0;
		energy_loss = '0;
		pseudorapidity = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		track_taken = 1'b0;
		gap_left = 0;
		calm_left = 0;
		cycle_count = 0;
		fail_count = 0;
		track_count = 0;
		result_count = 0;
		write_count = 0;
		setting_count = 1;
		drain_count = 0;
		for (i = 0; i < 4; i++) begin
			class_seen[i] = 0;
		end

		// The predictor starts from the reset values of the registers.
		cuts.eta_limit = dbpc_pkg::RST_ETA_LIMIT;
		cuts.pion_p_min = dbpc_pkg::RST_PION_P_MIN;
		cuts.pion_p_max = dbpc_pkg::RST_PION_P_MAX;
		cuts.pion_dedx_min = dbpc_pkg::RST_PION_DEDX_MIN;
		cuts.kaon_p_max = dbpc_pkg::RST_KAON_P_MAX;
		cuts.kaon_dedx_min = dbpc_pkg::RST_KAON_DEDX_MIN;
		cuts.proton_p_max = dbpc_pkg::RST_PROTON_P_MAX;
		cuts.proton_dedx_min = dbpc_pkg::RST_PROTON_DEDX_MIN;
		load_default_cuts();
		plan_eta_lim = int'(dbpc_pkg::RST_ETA_LIMIT);

		// Directed tracks under the reset setting. One clear pion, kaon and proton
		// each, then a track above the proton band.
		plan_track(2048, 256, 0);
		plan_track(2048, 1000, 0);
		plan_track(3000, 1500, 0);
		plan_track(3000, 5000, 0);
		// Eta cut: most negative eta, most positive eta, exactly at the limit on
		// both sides, and one step over it.
		plan_track(2048, 256, -32768);
		plan_track(2048, 256, 32767);
		plan_track(2048, 256, 3277);
		plan_track(2048, 256, 3278);
		plan_track(2048, 256, -3277);
		// Curve poles: zero momentum hits the pion and kaon lower curves, 205 the
		// kaon upper and proton lower curves, 614 the proton upper curve and the
		// pion minimum momentum.
		plan_track(0, 0, 0);
		plan_track(0, 65535, 0);
		plan_track(205, 2000, 0);
		plan_track(614, 2000, 0);
		plan_track(614, 100, 0);
		plan_track(615, 100, 0);
		// Strict momentum and energy loss cuts.
		plan_track(4095, 100, 0);
		plan_track(4096, 100, 0);
		plan_track(2048, 51, 0);
		plan_track(2048, 52, 0);
		plan_track(3685, 850, 0);
		plan_track(3686, 850, 0);
		// Field extremes.
		plan_track(65535, 65535, 0);
		plan_track(65535, 0, -1);
		plan_track(1, 65535, 1);
		plan_random_tracks(250);

		// Widest cuts: eta limit written with bit 15 set, minima zero, maxima full.
		next_cuts[dbpc_pkg::REG_ETA_LIMIT] = 16'hFFFF;
		next_cuts[dbpc_pkg::REG_PION_P_MIN] = 16'h0000;
		next_cuts[dbpc_pkg::REG_PION_P_MAX] = 16'hFFFF;
		next_cuts[dbpc_pkg::REG_PION_DEDX_MIN] = 16'h0000;
		next_cuts[dbpc_pkg::REG_KAON_P_MAX] = 16'hFFFF;
		next_cuts[dbpc_pkg::REG_KAON_DEDX_MIN] = 16'h0000;
		next_cuts[dbpc_pkg::REG_PROTON_P_MAX] = 16'hFFFF;
		next_cuts[dbpc_pkg::REG_PROTON_DEDX_MIN] = 16'h0000;
		plan_cuts();
		plan_random_tracks(100);

		// Tightest cuts: every register zero, so only eta zero passes the eta cut.
		for (i = 0; i < 8; i++) begin
			next_cuts[i] = 16'h0000;
		end
		plan_cuts();
		plan_random_tracks(100);

		for (i = 0; i < 3; i++) begin
			draw_random_cuts();
			plan_cuts();
			plan_random_tracks(170);
		end

		load_default_cuts();
		plan_cuts();
		plan_random_tracks(40);

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (track_plan_q.size() != 0 || start) begin
			@(posedge clk);
		end
		while (predicted_class_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d tracks over %0d register settings (%0d writes, %0d drains).",
			track_count, setting_count, write_count, drain_count);
		$display("Predicted none %0d, pion %0d, kaon %0d, proton %0d; %0d failures.",
			class_seen[dbpc_pkg::CLASS_NONE], class_seen[dbpc_pkg::CLASS_PION],
			class_seen[dbpc_pkg::CLASS_KAON], class_seen[dbpc_pkg::CLASS_PROTON], fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
